>>> rtl/core/cfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfb_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd2;

   // delay length held already clamped to 1..min(4095, MAX_DELAY)
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] gain;
      logic                       feedback;
      logic [LEN_W-1:0]           delay_len;
   } cfb_cfg_type;

endpackage

`default_nettype wire

>>> rtl/core/cfb_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface cfb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                channel;
   logic signed [cfb_pkg::SAMPLE_W-1:0] sample_in;
   logic                                block_end;

   modport source (output valid, output channel, output sample_in, output block_end,
                   input ready);
   modport sink   (input valid, input channel, input sample_in, input block_end,
                   output ready);
endinterface

interface cfb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cfb_pkg::SAMPLE_W-1:0] sample_out;
   logic                                block_end_out;

   modport source (output valid, output sample_out, output block_end_out, input ready);
   modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cfb_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module cfb_csr #(
   parameter int MAX_DELAY = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [cfb_pkg::CSR_IDX_W-1:0]     index,
   input  wire logic [cfb_pkg::CSR_DATA_W-1:0]    wdata,
   output cfb_pkg::cfb_cfg_type                   cfg
);

   localparam logic [16:0] MAX_W = 17'(MAX_DELAY);
   localparam logic [cfb_pkg::LEN_W-1:0] RESET_LEN =
      (MAX_DELAY < 2048) ? cfb_pkg::LEN_W'(MAX_DELAY) : cfb_pkg::LEN_W'(2048);

   cfb_pkg::cfb_cfg_type cfg_ff, cfg_in;
   logic [cfb_pkg::LEN_W-1:0] raw_len;
   logic [cfb_pkg::LEN_W-1:0] clamped_len;

   always_comb begin
      raw_len = wdata[cfb_pkg::LEN_W-1:0];
      if (raw_len == '0) begin
         clamped_len = cfb_pkg::LEN_W'(1);
      end else if (17'(raw_len) > MAX_W) begin
         clamped_len = cfb_pkg::LEN_W'(MAX_DELAY);
      end else begin
         clamped_len = raw_len;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            cfb_pkg::CSR_GAIN:     cfg_in.gain      = wdata;
            cfb_pkg::CSR_FEEDBACK: cfg_in.feedback  = wdata[0];
            cfb_pkg::CSR_DELAY:    cfg_in.delay_len = clamped_len;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain      <= '0;
         cfg_ff.feedback  <= 1'b0;
         cfg_ff.delay_len <= RESET_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/cfb_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module cfb_ring #(
   parameter int MAX_DELAY = 2048,
   parameter int CHANNELS  = 2,
   parameter int ADDR_W    = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          channel,
   input  wire logic [cfb_pkg::LEN_W-1:0]     delay_len,
   output logic [ADDR_W-1:0]                  addr,
   output logic                               in_range
);

   localparam int PW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int CW = ((PW > cfb_pkg::LEN_W) ? PW : cfb_pkg::LEN_W) + 1;

   logic [PW-1:0]     pos_ff [2];
   logic [PW-1:0]     pos_in;
   logic [PW-1:0]     slot;
   logic [CW-1:0]     len_ext;
   logic [CW-1:0]     nxt_ext;
   logic [ADDR_W:0]   addr_sum;

   assign in_range = (CHANNELS > 1) || !channel;
   assign len_ext  = CW'(delay_len);

   always_comb begin
      // a shortened delay can leave the position past the end
      slot    = (CW'(pos_ff[channel]) >= len_ext) ? '0 : pos_ff[channel];
      nxt_ext = CW'(slot) + CW'(1);
      pos_in  = (nxt_ext >= len_ext) ? '0 : PW'(nxt_ext);
      addr_sum = (ADDR_W+1)'(slot) +
                 ((channel && in_range) ? (ADDR_W+1)'(MAX_DELAY) : '0);
      addr = addr_sum[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            pos_ff[i] <= '0;
         end
      end else if (advance && in_range) begin
         pos_ff[channel] <= pos_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/cfb_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module cfb_mac (
   input  wire logic signed [cfb_pkg::SAMPLE_W-1:0] sample,
   input  wire logic signed [cfb_pkg::SAMPLE_W-1:0] delayed,
   input  wire logic signed [cfb_pkg::SAMPLE_W-1:0] gain,
   output logic signed [cfb_pkg::SAMPLE_W-1:0]      result
);

   logic signed [31:0] prod;
   logic signed [32:0] acc;
   logic signed [32:0] rnd;
   logic signed [17:0] quot;

   always_comb begin
      prod = gain * delayed;
      acc  = $signed({{2{sample[15]}}, sample, 15'd0}) + 33'(prod);
      // round half up, then floor shift
      rnd  = acc + 33'sd16384;
      quot = rnd[32:15];
      if (quot[17:15] == 3'b000 || quot[17:15] == 3'b111) begin
         result = quot[15:0];
      end else if (quot[17]) begin
         result = 16'sh8000;
      end else begin
         result = 16'sh7fff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/comb_filter_fir_iir.sv
`timescale 1ns / 1ps
`default_nettype none

// Comb filter, feedforward or feedback, one delay line per channel.
// A request is registered in the input stage, its result in the result stage.
// Throughput: one request, one store read and one write per cycle unless stalled.
// Reset: synchronous; the delay store is then zeroed one word a cycle,
// all min(CHANNELS, 2)*MAX_DELAY words (4096 by default), with req ready low.
module comb_filter_fir_iir #(
   parameter int MAX_DELAY = 2048,
   parameter int CHANNELS  = 2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cfb_req_if.sink                                 req_chan,
   cfb_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [cfb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cfb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NCH    = (CHANNELS > 1) ? 2 : 1;
   localparam int DEPTH  = NCH * MAX_DELAY;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW     = cfb_pkg::SAMPLE_W;

   cfb_pkg::cfb_cfg_type cfg;

   logic              accept;
   logic              s1_go;
   logic [ADDR_W-1:0] ring_addr;
   logic              ring_in_range;

   // input stage
   logic                 s1_valid_ff;
   logic signed [SW-1:0] s1_sample_ff;
   logic                 s1_block_end_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic                 s1_in_range_ff;

   // store
   logic [SW-1:0]        mem [DEPTH];
   logic [SW-1:0]        rd_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_wa;
   logic [SW-1:0]        mem_wd;

   // last write, covers a read issued at the same edge as that write
   logic                 fwd_valid_ff;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   logic [SW-1:0]        fwd_data_ff;

   logic                 clr_active_ff;
   logic [ADDR_W-1:0]    clr_addr_ff;

   logic signed [SW-1:0] delayed;
   logic signed [SW-1:0] mac_out;
   logic signed [SW-1:0] y;
   logic                 commit;

   // result stage
   logic                 rsp_valid_ff;
   logic signed [SW-1:0] rsp_sample_ff;
   logic                 rsp_block_end_ff;

   cfb_csr #(
      .MAX_DELAY (MAX_DELAY)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (csr_wr_en),
      .index  (csr_index),
      .wdata  (csr_wdata),
      .cfg    (cfg)
   );

   cfb_ring #(
      .MAX_DELAY (MAX_DELAY),
      .CHANNELS  (CHANNELS),
      .ADDR_W    (ADDR_W)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .channel   (req_chan.channel),
      .delay_len (cfg.delay_len),
      .addr      (ring_addr),
      .in_range  (ring_in_range)
   );

   assign s1_go          = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !clr_active_ff && (!s1_valid_ff || s1_go);
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff    <= req_chan.sample_in;
         s1_block_end_ff <= req_chan.block_end;
         s1_addr_ff      <= ring_addr;
         s1_in_range_ff  <= ring_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   assign delayed = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : rd_ff;

   cfb_mac u_mac (
      .sample  (s1_sample_ff),
      .delayed (delayed),
      .gain    (cfg.gain),
      .result  (mac_out)
   );

   // a channel beyond the configured count passes straight through
   assign y      = s1_in_range_ff ? mac_out : s1_sample_ff;
   assign commit = s1_valid_ff && s1_go && s1_in_range_ff;

   always_comb begin
      if (clr_active_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = '0;
      end else begin
         mem_we = commit;
         mem_wa = s1_addr_ff;
         mem_wd = cfg.feedback ? y : s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         rd_ff <= mem[ring_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (commit) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_valid_ff) begin
         rsp_sample_ff    <= y;
         rsp_block_end_ff <= s1_block_end_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sample_out    = rsp_sample_ff;
   assign rsp_chan.block_end_out = rsp_block_end_ff;

endmodule

`default_nettype wire

>>> sim/comb_filter_fir_iir_test.sv
`timescale 1ns / 1ps

module comb_filter_fir_iir_test;

   localparam int DEPTH       = 2048;
   localparam int NUM_CH      = 2;
   localparam int PHASE_REQS  = 210;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                                channel;
      logic signed [cfb_pkg::SAMPLE_W-1:0] sample;
      logic                                block_end;
   } audio_req_type;

   typedef struct packed {
      logic signed [cfb_pkg::SAMPLE_W-1:0] sample;
      logic                                block_end;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [cfb_pkg::CSR_IDX_W-1:0]  csr_index = cfb_pkg::CSR_GAIN;
   logic [cfb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cfb_req_if req_if ();
   cfb_rsp_if rsp_if ();

   comb_filter_fir_iir dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter settings as written to the block
   logic signed [cfb_pkg::SAMPLE_W-1:0] cfg_gain;
   logic                                cfg_feedback;
   logic [cfb_pkg::LEN_W-1:0]           cfg_delay;

   logic signed [cfb_pkg::SAMPLE_W-1:0] echo_line [NUM_CH][DEPTH];
   int unsigned                         tap_pos [NUM_CH];

   audio_req_type samples_to_send [$];
   filtered_type  filtered_due [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int cycles         = 0;

   function automatic void run_comb(input audio_req_type r);
      int unsigned                         span;
      int unsigned                         slot;
      logic signed [cfb_pkg::SAMPLE_W-1:0] past;
      longint                              acc;
      longint                              q;
      filtered_type                        res;
      span = (cfg_delay == 0) ? 1 : ((int'(cfg_delay) > DEPTH) ? DEPTH : int'(cfg_delay));
      slot = tap_pos[r.channel];
      if (slot >= span) slot = 0;   // delay was shortened under the write pointer
      past = echo_line[r.channel][slot];
      acc  = longint'(r.sample) * 32768 + longint'(cfg_gain) * longint'(past);
      q    = (acc + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.sample    = cfb_pkg::SAMPLE_W'(q);
      res.block_end = r.block_end;
      echo_line[r.channel][slot] = cfg_feedback ? res.sample : r.sample;
      slot++;
      if (slot >= span) slot = 0;
      tap_pos[r.channel] = slot;
      filtered_due.push_back(res);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // driver
   always @(posedge clock) begin : req_driver
      audio_req_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            run_comb('{req_if.channel, req_if.sample_in, req_if.block_end});
         if (!req_if.valid || req_if.ready) begin
            if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = samples_to_send.pop_front();
               req_if.valid     <= 1'b1;
               req_if.channel   <= nxt.channel;
               req_if.sample_in <= nxt.sample;
               req_if.block_end <= nxt.block_end;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      filtered_type want;
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (filtered_due.size() == 0) begin
            note_mismatch($sformatf("unexpected result: sample_out=%0d block_end_out=%0b",
                                    rsp_if.sample_out, rsp_if.block_end_out));
         end else begin
            want = filtered_due.pop_front();
            if (rsp_if.sample_out !== want.sample)
               note_mismatch($sformatf("sample_out mismatch: expected %0d, got %0d",
                                       want.sample, rsp_if.sample_out));
            if (rsp_if.block_end_out !== want.block_end)
               note_mismatch($sformatf("block_end_out mismatch: expected %0b, got %0b",
                                       want.block_end, rsp_if.block_end_out));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("comb_filter_fir_iir_test: FAIL");
         $finish;
      end
   end

   task automatic queue_req(input logic ch, input logic signed [cfb_pkg::SAMPLE_W-1:0] x,
                            input logic be);
      audio_req_type r;
      r.channel   = ch;
      r.sample    = x;
      r.block_end = be;
      samples_to_send.push_back(r);
   endtask

   task automatic wait_drained();
      while (samples_to_send.size() > 0 || req_if.valid || filtered_due.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all three registers, back to back; wr_en stays high across them
   task automatic set_filter(input logic signed [cfb_pkg::SAMPLE_W-1:0] g, input logic fb,
                             input logic [cfb_pkg::LEN_W-1:0] d);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= cfb_pkg::CSR_GAIN;
      csr_wdata <= g;
      @(posedge clock);
      csr_index <= cfb_pkg::CSR_FEEDBACK;
      csr_wdata <= {{(cfb_pkg::CSR_DATA_W-1){1'b0}}, fb};
      @(posedge clock);
      csr_index <= cfb_pkg::CSR_DELAY;
      csr_wdata <= {{(cfb_pkg::CSR_DATA_W-cfb_pkg::LEN_W){1'b0}}, d};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_gain     = g;
      cfg_feedback = fb;
      cfg_delay    = d;
   endtask

   function automatic logic signed [cfb_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0:       return 16'sh7fff;
         1:       return -16'sh8000;
         2:       return cfb_pkg::SAMPLE_W'($signed($urandom_range(0, 63)) - 32);
         default: return cfb_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic                                ch;
      logic signed [cfb_pkg::SAMPLE_W-1:0] g;
      logic                                fb;
      logic [cfb_pkg::LEN_W-1:0]           d;
      req_if.valid     = 1'b0;
      req_if.channel   = 1'b0;
      req_if.sample_in = '0;
      req_if.block_end = 1'b0;
      rsp_if.ready     = 1'b0;
      cfg_gain     = '0;
      cfg_feedback = 1'b0;
      cfg_delay    = cfb_pkg::LEN_W'(DEPTH);
      for (int c = 0; c < NUM_CH; c++) begin
         tap_pos[c] = 0;
         for (int i = 0; i < DEPTH; i++) echo_line[c][i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: pass-through
      queue_req(1'b0, 16'sh7fff, 1'b0);
      queue_req(1'b1, -16'sh8000, 1'b1);
      queue_req(1'b0, 16'sh0001, 1'b0);
      queue_req(1'b1, -16'sh0001, 1'b1);
      wait_drained();
      // half gain over the cleared store
      set_filter(16'sh4000, 1'b0, cfb_pkg::LEN_W'(DEPTH));
      queue_req(1'b0, 16'sh1234, 1'b0);
      queue_req(1'b1, -16'sh4321, 1'b0);
      queue_req(1'b0, 16'sh0000, 1'b1);
      wait_drained();
      // delay shortened below the positions, gain -1: saturation both ways
      set_filter(-16'sh8000, 1'b0, 12'd3);
      queue_req(1'b0, -16'sh8000, 1'b0);
      queue_req(1'b0, 16'sh7fff, 1'b0);
      queue_req(1'b0, 16'sh0001, 1'b0);
      queue_req(1'b0, 16'sh7fff, 1'b0);
      queue_req(1'b0, -16'sh8000, 1'b1);
      queue_req(1'b1, -16'sh0001, 1'b0);
      queue_req(1'b1, 16'sh0000, 1'b0);
      queue_req(1'b1, -16'sh8000, 1'b1);
      wait_drained();
      // delay zero acts as one, feedback near unit gain
      set_filter(16'sh7fff, 1'b1, 12'd0);
      queue_req(1'b0, 16'sh4000, 1'b0);
      queue_req(1'b0, 16'sh4000, 1'b0);
      queue_req(1'b0, 16'sh0001, 1'b0);
      queue_req(1'b1, -16'sh7000, 1'b0);
      queue_req(1'b1, -16'sh7000, 1'b1);
      wait_drained();
      // length above the store depth clamps
      set_filter(-16'sh0001, 1'b1, 12'd4095);
      queue_req(1'b0, 16'sh0003, 1'b1);
      queue_req(1'b1, -16'sh0003, 1'b0);
      wait_drained();

      ch = 1'b0;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin g = 16'sh7fff;  fb = 1'b0; d = 12'd5;                      end
            1: begin g = -16'sh8000; fb = 1'b1; d = cfb_pkg::LEN_W'(DEPTH);     end
            2: begin g = cfb_pkg::SAMPLE_W'($urandom); fb = 1'b0; d = 12'd1;   end
            3: begin g = -16'sh4000; fb = 1'b1; d = 12'd4095;                   end
            4: begin g = 16'sh7fff;  fb = 1'b1; d = cfb_pkg::LEN_W'($urandom_range(2, 12)); end
            5: begin g = cfb_pkg::SAMPLE_W'($urandom); fb = 1'b1; d = 12'd0;   end
            6: begin g = 16'sh0000;  fb = 1'b0; d = cfb_pkg::LEN_W'($urandom_range(1, 300)); end
            default: begin
               g  = cfb_pkg::SAMPLE_W'($urandom);
               fb = 1'($urandom);
               d  = cfb_pkg::LEN_W'($urandom_range(0, 4095));
            end
         endcase
         set_filter(g, fb, d);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
         endcase
         for (int i = 0; i < PHASE_REQS; i++) begin
            if ($urandom_range(0, 2) == 0) ch = ~ch;
            queue_req(ch, pick_sample(), ($urandom_range(0, 7) == 0));
            // sender holds off until the pipe is empty
            if (i == PHASE_REQS / 2) wait_drained();
         end
         wait_drained();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (mismatches == 0 && filtered_due.size() == 0)
         $display("comb_filter_fir_iir_test: PASS");
      else
         $display("comb_filter_fir_iir_test: FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/cfb_pkg.sv
rtl/core/cfb_ifs.sv
rtl/core/cfb_csr.sv
rtl/core/cfb_ring.sv
rtl/core/cfb_mac.sv
rtl/core/comb_filter_fir_iir.sv
sim/comb_filter_fir_iir_test.sv
